// ----- src/button_hold_classifier_core_defines.svh -----
// Assertion macros shared by the button hold classifier checkers.
// No dependencies; included by name from files that assert.
`ifndef BUTTON_HOLD_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_HOLD_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("button hold classifier check failed");

// Next-cycle implication, disabled while reset is held.
`define BHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("button hold classifier check failed");

`endif

// ----- src/bhc_pkg.sv -----
// Shared types and constants of the button hold classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bhc_pkg;

  // Default timestamp arithmetic width
  localparam int unsigned TIME_BITS_DEF = 32;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Register defaults after reset
  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [19:0] MENU_RST     = 20'd2000;
  localparam logic [19:0] TARE_RST     = 20'd10000;
  localparam logic [19:0] UNDO_RST     = 20'd15000;
  localparam logic [19:0] CONFIRM_RST  = 20'd3000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_MENU     = 3'd1,
    CFG_TARE     = 3'd2,
    CFG_UNDO     = 3'd3,
    CFG_CONFIRM  = 3'd4
  } cfg_idx_t;

  // Button phases
  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_DEB_PRESS   = 2'd1,
    PH_HOLDING     = 2'd2,
    PH_DEB_RELEASE = 2'd3
  } phase_t;

  // Reported actions
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_HINT   = 3'd1,
    ACT_PROMPT = 3'd2,
    ACT_ENTER  = 3'd3,
    ACT_CANCEL = 3'd4,
    ACT_TARE   = 3'd5,
    ACT_UNDO   = 3'd6
  } action_t;

  // Current register values
  typedef struct packed {
    logic [15:0] debounce_time;
    logic [19:0] menu_hold_time;
    logic [19:0] tare_hold_time;
    logic [19:0] undo_hold_time;
    logic [19:0] confirm_window;
  } cfg_t;

  // One poll
  typedef struct packed {
    logic        pressed;
    logic [31:0] now_ms;
  } in_item_t;

  // One result
  typedef struct packed {
    action_t     action;
    logic        activity_mark;
    logic        holding;
    logic [31:0] hold_elapsed;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/bhc_cfg_regs.sv -----
// Configuration register file of the button hold classifier.
// Depends on bhc_pkg for the register indexes, defaults and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module bhc_cfg_regs
  import bhc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode one write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: cfg_nxt.debounce_time  = cfg_data[15:0];
        CFG_MENU:     cfg_nxt.menu_hold_time = cfg_data;
        CFG_TARE:     cfg_nxt.tare_hold_time = cfg_data;
        CFG_UNDO:     cfg_nxt.undo_hold_time = cfg_data;
        CFG_CONFIRM:  cfg_nxt.confirm_window = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time  <= DEBOUNCE_RST;
      cfg_r.menu_hold_time <= MENU_RST;
      cfg_r.tare_hold_time <= TARE_RST;
      cfg_r.undo_hold_time <= UNDO_RST;
      cfg_r.confirm_window <= CONFIRM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/bhc_fsm.sv -----
// Debounce and hold classification state machine: phase, timestamps,
// prompt flag, and the per-poll result. Depends on bhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bhc_fsm
  import bhc_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire cfg_t     cfg,
  input  wire in_item_t item,
  output out_item_t     res
);

  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] press_r, press_nxt;
  logic [TIME_BITS-1:0] deb_r, deb_nxt;
  logic [TIME_BITS-1:0] win_r, win_nxt;
  logic                 prompt_r, prompt_nxt;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] d_press, d_deb, d_win;
  logic [63:0]          d_press64, d_deb64, d_win64;
  logic                 deb_exp, win_exp, menu_exp, tare_exp, undo_exp;
  logic                 pr;
  action_t              act;
  logic                 mark;

  // Timestamp folded to the arithmetic width
  assign now_t = TIME_BITS'(64'(item.now_ms));
  assign pr    = item.pressed;

  // Wrapping elapsed times
  assign d_press = now_t - press_r;
  assign d_deb   = now_t - deb_r;
  assign d_win   = now_t - win_r;

  assign d_press64 = 64'(d_press);
  assign d_deb64   = 64'(d_deb);
  assign d_win64   = 64'(d_win);

  // Timeout flags; a zero length counts as elapsed
  assign deb_exp  = d_deb64   >= 64'(cfg.debounce_time);
  assign win_exp  = d_win64   >= 64'(cfg.confirm_window);
  assign menu_exp = d_press64 >= 64'(cfg.menu_hold_time);
  assign tare_exp = d_press64 >= 64'(cfg.tare_hold_time);
  assign undo_exp = d_press64 >= 64'(cfg.undo_hold_time);

  // Next state and action
  always_comb begin
    phase_nxt  = phase_r;
    press_nxt  = press_r;
    deb_nxt    = deb_r;
    win_nxt    = win_r;
    prompt_nxt = prompt_r;
    act        = ACT_NONE;
    mark       = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        // window expiry wins over the level
        if (prompt_r && win_exp) begin
          prompt_nxt = 1'b0;
          act        = ACT_CANCEL;
        end else if (pr) begin
          deb_nxt   = now_t;
          phase_nxt = PH_DEB_PRESS;
        end
      end
      PH_DEB_PRESS: begin
        if (deb_exp) begin
          if (!pr) begin
            phase_nxt = PH_IDLE;
          end else begin
            mark       = 1'b1;
            prompt_nxt = 1'b0;
            if (prompt_r && !win_exp) begin
              phase_nxt = PH_IDLE;
              act       = ACT_ENTER;
            end else begin
              press_nxt = now_t;
              phase_nxt = PH_HOLDING;
              act       = ACT_HINT;
            end
          end
        end
      end
      PH_HOLDING: begin
        if (pr) begin
          if (!prompt_r && menu_exp && !tare_exp) begin
            prompt_nxt = 1'b1;
            win_nxt    = now_t;
            act        = ACT_PROMPT;
          end else begin
            act = ACT_HINT;
          end
        end else begin
          deb_nxt   = now_t;
          phase_nxt = PH_DEB_RELEASE;
        end
      end
      PH_DEB_RELEASE: begin
        if (deb_exp) begin
          if (pr) begin
            phase_nxt = PH_HOLDING;
            act       = ACT_HINT;
          end else begin
            mark      = 1'b1;
            phase_nxt = PH_IDLE;
            // undo is tested before tare
            if (undo_exp) begin
              prompt_nxt = 1'b0;
              act        = ACT_UNDO;
            end else if (tare_exp) begin
              prompt_nxt = 1'b0;
              act        = ACT_TARE;
            end else if (prompt_r) begin
              win_nxt = now_t;
            end
          end
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Result; a fresh hold starts at zero elapsed
  always_comb begin
    res.action        = act;
    res.activity_mark = mark;
    res.holding       = (phase_nxt == PH_HOLDING);
    res.hold_elapsed  = '0;
    if (phase_nxt == PH_HOLDING && phase_r != PH_DEB_PRESS) begin
      res.hold_elapsed = d_press64[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      press_r  <= '0;
      deb_r    <= '0;
      win_r    <= '0;
      prompt_r <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      press_r  <= press_nxt;
      deb_r    <= deb_nxt;
      win_r    <= win_nxt;
      prompt_r <= prompt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/button_hold_classifier_core.sv -----
// Top level of the button hold classifier: input register, state machine,
// result register. Depends on bhc_pkg, bhc_cfg_regs and bhc_fsm.
//
// Button poll classifier. Each input item is one poll (button level and a
// wrapping millisecond timestamp); each poll yields exactly one result item,
// loaded into the result register from the input register once the result
// register is free or drains. One poll is taken every clock while the input
// is not stalled: the whole debounce and classification step for an item is
// a single pass of subtract and compare logic between the input register and
// the result register. While a result is stalled the input register still
// takes one more poll; only then does the input stall. Configuration writes
// are taken at any time (cfg_ready is always high) but must only be issued
// while no poll is in flight.
`timescale 1ns / 1ps
`default_nettype none

module button_hold_classifier_core
  import bhc_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // poll input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t step_res;
  logic      advance;
  logic      in_take;

  bhc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Item moves to the result register when that register is free or drains
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  bhc_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .cfg     (cfg),
    .item    (s1_item_r),
    .res     (step_res)
  );

  // Valid flags of both stages
  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- src/bhc_checker.sv -----
// Port-level checks for the button hold classifier, bound to the top level.
// Depends on bhc_pkg and button_hold_classifier_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "button_hold_classifier_core_defines.svh"

module bhc_checker
  import bhc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // A stalled result stays put
  `BHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_item))

  // With the result register empty the input never stalls
  `BHC_ASSERT_NOW(a_no_idle_stall, clk, rst_n, !out_valid, !in_stall)

  // Elapsed time is reported only while holding
  `BHC_ASSERT_NOW(a_elapsed_zero, clk, rst_n, out_valid && !out_item.holding,
                  out_item.hold_elapsed == 32'd0)

  // While holding only a hint or the prompt can be reported
  `BHC_ASSERT_NOW(a_hold_action, clk, rst_n, out_valid && out_item.holding,
                  out_item.action == ACT_HINT || out_item.action == ACT_PROMPT)

  // Activity is never marked with a prompt or a cancel
  `BHC_ASSERT_NOW(a_mark_action, clk, rst_n, out_valid && out_item.activity_mark,
                  out_item.action != ACT_PROMPT && out_item.action != ACT_CANCEL)

endmodule

bind button_hold_classifier_core bhc_checker u_bhc_checker (.*);

`default_nettype wire

// ----- verif/button_hold_classifier_core_tb.sv -----
// Self-checking testbench for button_hold_classifier_core: directed polls at the defaults,
// then random press/hold/release sequences under several timing settings and idling modes.
// Depends on bhc_pkg and the RTL only; expected results come from a built-in predictor.
`timescale 1ns / 1ps

module button_hold_classifier_core_tb;
  import bhc_pkg::*;

  localparam int STUCK_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  button_hold_classifier_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Polls waiting to be driven, results waiting to arrive
  in_item_t polls_pending[$];
  out_item_t results_due[$];
  out_item_t due_result;

  // Predicted button state and register copy
  phase_t btn_phase;
  logic [31:0] press_t;
  logic [31:0] deb_t;
  logic [31:0] win_t;
  logic prompt_on;
  cfg_t regs;

  int fault_count;
  int stuck_cycles;
  int send_gap_pct;
  int recv_stall_pct;
  logic in_took;
  logic [31:0] clock_ms;
  int poll_budget;

  // Directed script at the reset timings, offsets from a base just below the wrap
  int unsigned script_ofs [32] = '{
    100, 150, 205, 255, 256, 2255, 2300, 2350, 2400, 2450,
    5450, 5460, 5510, 7510, 7600, 7650, 10640, 10690, 20000, 20640, 20690,
    20700, 20750, 22750, 22800, 22850, 25000, 25050, 25100, 25150, 40100, 40150
  };
  bit script_lvl [32] = '{
    1, 0, 1, 1, 1, 1, 0, 1, 0, 0,
    1, 1, 1, 1, 0, 0, 1, 1, 1, 0, 0,
    1, 1, 1, 0, 0, 1, 1, 1, 1, 0, 0
  };

  always #1 clk = ~clk;

  // Timeout of span since start, with wrapping difference
  function automatic logic lapsed(logic [31:0] now, logic [31:0] start, logic [31:0] span);
    logic [31:0] diff;
    diff = now - start;
    return diff >= span;
  endfunction

  // One poll through the debounce/hold machine; queues the expected result
  task automatic classify_poll(input in_item_t poll);
    out_item_t r;
    logic [31:0] t;
    logic [31:0] held;
    logic lv;
    t = poll.now_ms;
    lv = poll.pressed;
    r = '0;
    r.action = ACT_NONE;
    case (btn_phase)
      PH_IDLE: begin
        // window expiry wins over the level
        if (prompt_on && lapsed(t, win_t, regs.confirm_window)) begin
          prompt_on = 1'b0;
          r.action = ACT_CANCEL;
        end else if (lv) begin
          deb_t = t;
          btn_phase = PH_DEB_PRESS;
        end
      end
      PH_DEB_PRESS: begin
        if (lapsed(t, deb_t, regs.debounce_time)) begin
          if (!lv) begin
            btn_phase = PH_IDLE;
          end else begin
            r.activity_mark = 1'b1;
            if (prompt_on && !lapsed(t, win_t, regs.confirm_window)) begin
              prompt_on = 1'b0;
              btn_phase = PH_IDLE;
              r.action = ACT_ENTER;
            end else begin
              // late second press is just a new hold
              prompt_on = 1'b0;
              press_t = t;
              btn_phase = PH_HOLDING;
              r.action = ACT_HINT;
            end
          end
        end
      end
      PH_HOLDING: begin
        if (lv) begin
          if (!prompt_on && lapsed(t, press_t, regs.menu_hold_time) &&
              !lapsed(t, press_t, regs.tare_hold_time)) begin
            prompt_on = 1'b1;
            win_t = t;
            r.action = ACT_PROMPT;
          end else begin
            r.action = ACT_HINT;
          end
        end else begin
          deb_t = t;
          btn_phase = PH_DEB_RELEASE;
        end
      end
      default: begin
        if (lapsed(t, deb_t, regs.debounce_time)) begin
          if (lv) begin
            btn_phase = PH_HOLDING;
            r.action = ACT_HINT;
          end else begin
            r.activity_mark = 1'b1;
            btn_phase = PH_IDLE;
            held = t - press_t;
            // undo checked first, so tare above undo still yields undo
            if (held >= regs.undo_hold_time) begin
              prompt_on = 1'b0;
              r.action = ACT_UNDO;
            end else if (held >= regs.tare_hold_time) begin
              prompt_on = 1'b0;
              r.action = ACT_TARE;
            end else if (prompt_on) begin
              win_t = t;
            end
          end
        end
      end
    endcase
    r.holding = (btn_phase == PH_HOLDING);
    r.hold_elapsed = r.holding ? t - press_t : 32'd0;
    results_due.push_back(r);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    fault_count++;
    $display("ERROR %s: got %0h, want %0h at %0t", what, got, want, $realtime);
  endtask

  // Check results, predict accepted polls, track register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          note_mismatch("result with nothing due", out_item.action, ACT_NONE);
        end else begin
          due_result = results_due.pop_front();
          if (out_item.action !== due_result.action)
            note_mismatch("action", out_item.action, due_result.action);
          if (out_item.activity_mark !== due_result.activity_mark)
            note_mismatch("activity_mark", out_item.activity_mark, due_result.activity_mark);
          if (out_item.holding !== due_result.holding)
            note_mismatch("holding", out_item.holding, due_result.holding);
          if (out_item.hold_elapsed !== due_result.hold_elapsed)
            note_mismatch("hold_elapsed", out_item.hold_elapsed, due_result.hold_elapsed);
        end
      end
      if (in_valid && !in_stall)
        classify_poll(in_item);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEBOUNCE: regs.debounce_time = cfg_data[15:0];
          CFG_MENU:     regs.menu_hold_time = cfg_data;
          CFG_TARE:     regs.tare_hold_time = cfg_data;
          CFG_UNDO:     regs.undo_hold_time = cfg_data;
          CFG_CONFIRM:  regs.confirm_window = cfg_data;
          default: ;
        endcase
      end
    end
    in_took <= rst_n && in_valid && !in_stall;
  end

  // Poll driver: hold the item until taken, random gaps between items
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (polls_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_item <= polls_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("button_hold_classifier_core: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (polls_pending.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_poll(input bit lvl, input logic [31:0] dt);
    in_item_t p;
    clock_ms = clock_ms + dt;
    p.pressed = lvl;
    p.now_ms = clock_ms;
    polls_pending.push_back(p);
    poll_budget--;
  endtask

  // Spread one steady level over a few polls covering exactly span ms
  task automatic hold_level(input bit lvl, input longint unsigned span, input int parts);
    longint unsigned step;
    step = span / parts;
    for (int i = 0; i < parts; i++)
      push_poll(lvl, (i == parts - 1) ? span - step * (parts - 1) : step);
  endtask

  function automatic longint unsigned around(input longint unsigned x);
    longint v;
    v = longint'(x) + $urandom_range(0, 4) - 2;
    return (v < 0) ? 0 : v;
  endfunction

  // Press with optional bounce, hold of chosen length, release, idle gap
  task automatic push_episode();
    longint unsigned d, menu, tare, undo, win, hold, gap;
    d = regs.debounce_time;
    menu = regs.menu_hold_time;
    tare = regs.tare_hold_time;
    undo = regs.undo_hold_time;
    win = regs.confirm_window;
    case ($urandom_range(4))
      0: hold = $urandom_range(0, menu);
      1: hold = around(menu);
      2: hold = around(tare);
      3: hold = around(undo);
      default: hold = $urandom_range(0, undo + undo / 4 + 1);
    endcase
    repeat ($urandom_range(0, 2)) push_poll($urandom_range(1), $urandom_range(0, d));
    push_poll(1'b1, $urandom_range(1, d + 1));
    hold_level(1'b1, d + hold, $urandom_range(1, 6));
    // short dropout during the hold
    if ($urandom_range(4) == 0) begin
      push_poll(1'b0, 1);
      push_poll(1'b1, $urandom_range(0, d));
    end
    push_poll(1'b0, $urandom_range(1, d + 1));
    if ($urandom_range(3) == 0) push_poll(1'b1, $urandom_range(0, d));
    hold_level(1'b0, d, $urandom_range(1, 3));
    gap = $urandom_range(0, win + win / 2 + 2);
    hold_level(1'b0, gap, $urandom_range(1, 3));
  endtask

  task automatic push_noise();
    longint unsigned d;
    d = regs.debounce_time;
    repeat ($urandom_range(3, 10))
      push_poll($urandom_range(1),
                ($urandom_range(7) == 0) ? $urandom() : $urandom_range(0, 2 * d + 2));
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] menu,
                           input logic [CFG_DATA_W-1:0] tare, input logic [CFG_DATA_W-1:0] undo,
                           input logic [CFG_DATA_W-1:0] win, input int gap_pct,
                           input int stall_pct, input int n_polls);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_MENU, menu);
    write_reg(CFG_TARE, tare);
    write_reg(CFG_UNDO, undo);
    write_reg(CFG_CONFIRM, win);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    @(posedge clk);
    clock_ms = $urandom();
    poll_budget = n_polls;
    while (poll_budget > 0) begin
      if ($urandom_range(5) == 0) push_noise();
      else push_episode();
    end
    wait_drained();
  endtask

  initial begin
    in_item_t p;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_took = 1'b0;
    fault_count = 0;
    stuck_cycles = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    btn_phase = PH_IDLE;
    press_t = '0;
    deb_t = '0;
    win_t = '0;
    prompt_on = 1'b0;
    regs = '{debounce_time: DEBOUNCE_RST, menu_hold_time: MENU_RST,
             tare_hold_time: TARE_RST, undo_hold_time: UNDO_RST,
             confirm_window: CONFIRM_RST};

    // Directed: bounce reject, exact thresholds, cancel, late second press,
    // tare, enter and undo, with the press landing on the timestamp wrap
    foreach (script_ofs[i]) begin
      p.pressed = script_lvl[i];
      p.now_ms = 32'hFFFF_FF00 + script_ofs[i];
      polls_pending.push_back(p);
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // Random sequences under several timings and idling modes
    run_phase(4, 30, 90, 140, 50, 0, 0, 120);
    run_phase(0, 0, 0, 0, 0, 50, 0, 60);
    run_phase($urandom_range(0, 8), $urandom_range(10, 60), $urandom_range(40, 120),
              $urandom_range(60, 200), $urandom_range(10, 80), 0, 50, 120);
    run_phase(5, 40, 150, 100, 60, 29, 29, 100);
    run_phase(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 0, 50, 50);
    run_phase(DEBOUNCE_RST, MENU_RST, TARE_RST, UNDO_RST, CONFIRM_RST, 29, 29, 100);
    // write to an unmapped index must change nothing
    write_reg(3'(CFG_CONFIRM) + 3'($urandom_range(1, 3)), 20'($urandom()));
    run_phase(3, 25, 70, 110, 40, 0, 0, 40);

    repeat (8) @(posedge clk);
    if (fault_count == 0 && results_due.size() == 0)
      $display("button_hold_classifier_core: match");
    else
      $display("button_hold_classifier_core: mismatch");
    $finish;
  end

endmodule
